>>> sv/pdls_pkg.sv
// Package for the PD line-steering block: field widths, reset values and mode codes.
// Used by pd_differential_line_steering, pdls_div and the checker; depends on nothing.
package pdls_pkg;
  localparam int unsigned CHANNELS_DEF = 5;
  localparam int unsigned PEAK_RESET_DEF = 3000;
  localparam int unsigned RAW_W = 12;
  localparam int unsigned DUTY_W = 14;
  localparam int unsigned DUTY_MAX = 16383;
  localparam int unsigned PCT_SCALE = 25600;
  localparam int unsigned PD_WEIGHT = 7;

  localparam logic [13:0] BASE_RST = 14'd2500;
  localparam logic [11:0] KP_RST = 12'd486;
  localparam logic [11:0] KD_RST = 12'd717;
  localparam logic [12:0] TURN_RST = 13'd500;
  localparam logic [11:0] LOST_RST = 12'd50;
  localparam logic [13:0] CEIL_RST = 14'd7000;
  localparam logic [13:0] FLOOR_RST = 14'd1400;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_KP = 3'd1;
  localparam logic [2:0] REG_KD = 3'd2;
  localparam logic [2:0] REG_TURN = 3'd3;
  localparam logic [2:0] REG_LOST = 3'd4;
  localparam logic [2:0] REG_CEIL = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;

  localparam logic [1:0] MODE_TURN = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_LOST = 2'd2;
endpackage

>>> sv/pdls_div.sv
// Restoring divider, one quotient bit per cycle, shared by normalization and the error.
// Depends on pdls_pkg for nothing beyond house style; widths come from parameters.
module pdls_div import pdls_pkg::*; #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DW:0] trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        d <= den;
        rem <= '0;
        cnt <= CW'(NW);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/pd_differential_line_steering.sv
// Top level of the PD line-steering block: peaks, normalization, PD law, duty clamps.
// Depends on pdls_pkg and on pdls_div for every division.
//
//  channel   | width | fields (lowest bit up)
//  s_axis    | 120   | raw_left_outer .. raw_right_outer, filt_left_outer .. filt_right_outer
//  m_axis    | 32    | left_duty, right_duty, steer_mode
//  cfg       | 18    | cfg_we, cfg_index, cfg_data
//
// One beat runs three divisions in turn (start, 31 quotient bits, done): two
// normalizations and the error, then S_MUL, S_ACC and S_DUTY to the result and S_OUT back
// to idle, so a beat is taken only in idle and the rate is set by the bit-serial divider.
// Reset is synchronous; it loads the register defaults and all peaks.
// A result waits in the output register; the next beat is taken while it waits, and
// the block stalls at its end only if the previous result has not yet been taken.
module pd_differential_line_steering import pdls_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned PEAK_RESET = PEAK_RESET_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [13:0]  cfg_data
);
  localparam logic [11:0] PK_RST = 12'(PEAK_RESET);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_NA = 8'b00000010, S_NB = 8'b00000100,
    S_ERR = 8'b00001000, S_MUL = 8'b00010000, S_ACC = 8'b00100000,
    S_DUTY = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state;
  logic [13:0] base_speed, duty_ceiling, duty_floor;
  logic [11:0] kp, kd, lost_th;
  logic [12:0] turn_th;
  logic [11:0] peak [CHANNELS];
  logic signed [15:0] prev_err;

  logic [11:0] raw [5];
  logic [11:0] filt [5];
  logic turn;
  logic [15:0] na, nb;
  logic signed [15:0] err;
  logic signed [29:0] pterm, dterm;
  logic signed [33:0] acc;
  logic signed [19:0] corr;

  logic div_start, div_done;
  logic [30:0] div_num, div_quo;
  logic [16:0] div_den;

  pdls_div #(.NW(31), .DW(17)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  function automatic logic [11:0] peak_sel(input int unsigned ch, input logic [11:0] r,
                                           input logic [11:0] p);
    peak_sel = (ch < CHANNELS) ? ((r > p) ? r : p) : PK_RST;
  endfunction

  logic [11:0] pa, pb, fa, fb;
  logic [16:0] esum;
  logic [15:0] ediff;
  logic eneg;
  logic signed [16:0] eq;
  logic signed [35:0] accw;
  logic signed [20:0] lsum, rsum;
  logic [13:0] lsat, rsat;

  always_comb begin
    pa = turn ? peak_sel(1, raw[1], (CHANNELS > 1) ? peak[1 % CHANNELS] : PK_RST)
              : peak_sel(0, raw[0], peak[0]);
    pb = turn ? peak_sel(3, raw[3], (CHANNELS > 3) ? peak[3 % CHANNELS] : PK_RST)
              : peak_sel(4, raw[4], (CHANNELS > 4) ? peak[4 % CHANNELS] : PK_RST);
    fa = turn ? filt[1] : filt[0];
    fb = turn ? filt[3] : filt[4];
    esum = {1'b0, na} + {1'b0, nb};
    eneg = na > nb;
    ediff = eneg ? na - nb : nb - na;
    if (state == S_NB) begin
      div_num = 31'(fb) * 31'(PCT_SCALE);
      div_den = 17'(pb);
    end else if (state == S_ERR) begin
      div_num = (esum == 0) ? 31'd0 : 31'(ediff) * 31'(PCT_SCALE);
      div_den = (esum == 0) ? 17'd1 : esum;
    end else begin
      div_num = 31'(fa) * 31'(PCT_SCALE);
      div_den = 17'(pa);
    end
    eq = eneg ? -$signed({1'b0, div_quo[15:0]}) : $signed({1'b0, div_quo[15:0]});
    accw = 36'(acc) * 36'sd7;
    corr = 20'(accw < 0 ? -((-accw) >>> 16) : accw >>> 16);
    lsum = $signed({7'b0, base_speed}) + 21'(corr);
    rsum = $signed({7'b0, base_speed}) - 21'(corr);
    lsat = lsum < 0 ? 14'd0 : (lsum > 21'sd16383 ? 14'(DUTY_MAX) : lsum[13:0]);
    rsat = rsum < 0 ? 14'd0 : (rsum > 21'sd16383 ? 14'(DUTY_MAX) : rsum[13:0]);
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      div_start <= 1'b0;
      base_speed <= BASE_RST; kp <= KP_RST; kd <= KD_RST; turn_th <= TURN_RST;
      lost_th <= LOST_RST; duty_ceiling <= CEIL_RST; duty_floor <= FLOOR_RST;
      for (int i = 0; i < CHANNELS; i++) peak[i] <= PK_RST;
      prev_err <= '0;
    end else begin
      div_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state != S_DUTY) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE: base_speed <= cfg_data;
          REG_KP: kp <= cfg_data[11:0];
          REG_KD: kd <= cfg_data[11:0];
          REG_TURN: turn_th <= cfg_data[12:0];
          REG_LOST: lost_th <= cfg_data[11:0];
          REG_CEIL: duty_ceiling <= cfg_data;
          REG_FLOOR: duty_floor <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 5; i++) begin
              raw[i] <= s_axis_tdata[12*i +: 12];
              filt[i] <= s_axis_tdata[60 + 12*i +: 12];
            end
            turn <= ({1'b0, s_axis_tdata[23:12]} + {1'b0, s_axis_tdata[47:36]}) >= turn_th;
            state <= S_NA;
            div_start <= 1'b1;
            na <= '0;
          end
        end
        S_NA: begin
          if (div_done) begin
            na <= (div_quo > 31'hFFFF || pa == 0) ? 16'hFFFF : div_quo[15:0];
            div_start <= 1'b1;
            state <= S_NB;
          end
        end
        S_NB: begin
          if (div_done) begin
            nb <= (div_quo > 31'hFFFF || pb == 0) ? 16'hFFFF : div_quo[15:0];
            state <= S_ERR;
            div_start <= 1'b1;
          end
        end
        S_ERR: begin
          if (div_done) begin
            err <= eq[15:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pterm <= 30'(err) * $signed({18'b0, kp});
          dterm <= 30'($signed({err[15], err}) - $signed({prev_err[15], prev_err}))
                   * $signed({18'b0, kd});
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= 34'(pterm) + 34'(dterm);
          prev_err <= err;
          for (int i = 0; i < CHANNELS; i++)
            if (i < 5 && raw[i % 5] > peak[i]) peak[i] <= raw[i % 5];
          state <= S_DUTY;
        end
        S_DUTY: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            if (turn) begin
              m_axis_tdata <= err > 0 ? {2'b0, MODE_TURN, 14'd0, lsat}
                                      : {2'b0, MODE_TURN, rsat, 14'd0};
            end else if (raw[2] < lost_th) begin
              m_axis_tdata <= {2'b0, MODE_LOST, 28'd0};
            end else begin
              m_axis_tdata <= {2'b0, MODE_NORMAL,
                rsat > duty_ceiling ? duty_ceiling : (rsat < duty_floor ? 14'd0 : rsat),
                lsat > duty_ceiling ? duty_ceiling : (lsat < duty_floor ? 14'd0 : lsat)};
            end
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/pdls_checker.sv
// Port-level checker for the PD line-steering block, bound to the top level.
// Depends on pdls_pkg for the mode codes.
module pdls_checker import pdls_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed");
  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[29:28] != 2'd3)
    else $error("bad steer mode");
  a_lost: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[29:28] == MODE_LOST |-> m_axis_tdata[27:0] == 28'd0)
    else $error("stopped wheels not zero");
  a_turn: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[29:28] == MODE_TURN
      |-> m_axis_tdata[13:0] == 14'd0 || m_axis_tdata[27:14] == 14'd0)
    else $error("sharp turn drives both wheels");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");
endmodule

bind pd_differential_line_steering pdls_checker u_pdls_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

>>> sim/tb_top.sv
// Testbench for pd_differential_line_steering: random coil readings and register settings.
// Holds a scoreboard class with its own PD steering predictor; depends on pdls_pkg and the DUT.
module tb_top;
  import pdls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  steer_mode;
    logic [13:0] right_duty;
    logic [13:0] left_duty;
  } duty_t;

  class steer_scoreboard;
    logic [11:0] peak [5];
    longint prev_err;
    longint base, kp, kd, turn, lost, ceil_v, floor_v;
    duty_t duty_q[$];
    int errors;

    function void clear();
      for (int i = 0; i < 5; i++) peak[i] = 12'(PEAK_RESET_DEF);
      prev_err = 0;
      base = BASE_RST; kp = KP_RST; kd = KD_RST; turn = TURN_RST;
      lost = LOST_RST; ceil_v = CEIL_RST; floor_v = FLOOR_RST;
      duty_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [13:0] v);
      case (idx)
        REG_BASE: base = v;
        REG_KP: kp = v[11:0];
        REG_KD: kd = v[11:0];
        REG_TURN: turn = v[12:0];
        REG_LOST: lost = v[11:0];
        REG_CEIL: ceil_v = v;
        REG_FLOOR: floor_v = v;
        default: ;
      endcase
    endfunction

    function longint pct_error(longint a, longint b);
      if (a + b == 0) return 0;
      return ((b - a) * longint'(PCT_SCALE)) / (a + b);
    endfunction

    function longint sat(longint v);
      if (v < 0) return 0;
      if (v > longint'(DUTY_MAX)) return longint'(DUTY_MAX);
      return v;
    endfunction

    function longint clamp(longint d);
      if (d > ceil_v) return ceil_v;
      if (d < floor_v) return 0;
      return d;
    endfunction

    function void note_input(logic [119:0] beat);
      longint raw [5];
      longint norm [5];
      longint e, c, q;
      duty_t r;
      for (int i = 0; i < 5; i++) begin
        raw[i] = beat[12*i +: 12];
        if (raw[i] > peak[i]) peak[i] = 12'(raw[i]);
      end
      for (int i = 0; i < 5; i++) begin
        q = (longint'(beat[60 + 12*i +: 12]) * longint'(PCT_SCALE)) / longint'(peak[i]);
        norm[i] = (q > 65535) ? 65535 : q;
      end
      r = '0;
      if (raw[1] + raw[3] >= turn) begin
        r.steer_mode = MODE_TURN;
        e = pct_error(norm[1], norm[3]);
        c = (longint'(PD_WEIGHT) * (e * kp + (e - prev_err) * kd)) / 65536;
        if (e > 0) r.left_duty = 14'(sat(base + c));
        else r.right_duty = 14'(sat(base - c));
      end else begin
        e = pct_error(norm[0], norm[4]);
        c = (longint'(PD_WEIGHT) * (e * kp + (e - prev_err) * kd)) / 65536;
        if (raw[2] >= lost) begin
          r.steer_mode = MODE_NORMAL;
          r.left_duty = 14'(clamp(sat(base + c)));
          r.right_duty = 14'(clamp(sat(base - c)));
        end else r.steer_mode = MODE_LOST;
      end
      prev_err = e;
      duty_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] data);
      duty_t got, exp_r;
      got = data[29:0];
      if (duty_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      exp_r = duty_q.pop_front();
      if (got !== exp_r || data[31:30] !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected L=%0d R=%0d M=%0d, got L=%0d R=%0d M=%0d",
                   exp_r.left_duty, exp_r.right_duty, exp_r.steer_mode,
                   got.left_duty, got.right_duty, got.steer_mode);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  steer_scoreboard sb;
  bit stim_done = 0;
  longint cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  pd_differential_line_steering u_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        if (gap > 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [13:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_beat(logic [119:0] d, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(6);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.duty_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [11:0] rnd12();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(60));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [119:0] rnd_beat();
    logic [119:0] d;
    for (int i = 0; i < 10; i++) d[12*i +: 12] = rnd12();
    if ($urandom_range(2) == 0) begin
      d[23:12] = 12'($urandom_range(300));
      d[47:36] = 12'($urandom_range(300));
    end
    return d;
  endfunction

  function automatic logic [13:0] rnd_reg(int idx);
    case ($urandom_range(4))
      0: return 14'd0;
      1: return (idx == 3) ? 14'd8190 : (idx == 0) ? 14'd10000 :
                (idx inside {1, 2, 4}) ? 14'd4095 : 14'd16383;
      default: return (idx == 0) ? 14'($urandom_range(10000)) :
                      (idx == 3) ? 14'($urandom_range(1200)) :
                      (idx == 4) ? 14'($urandom_range(300)) :
                      (idx == 5) ? 14'($urandom_range(4000, 16383)) :
                      (idx == 6) ? 14'($urandom_range(3000)) : 14'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [119:0] d;
    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_beat('0, 0);
    send_beat({120{1'b1}}, 0);
    d = '0; d[35:24] = 12'd100; d[71:60] = 12'd2000; send_beat(d, 0);
    d[119:108] = 12'd2000; d[71:60] = 12'd0; send_beat(d, 0);
    d = '0; d[23:12] = 12'd400; d[47:36] = 12'd400; d[83:72] = 12'd3000;
    send_beat(d, 0);
    d[83:72] = 12'd0; d[107:96] = 12'd3000; send_beat(d, 0);
    d = '0; d[35:24] = 12'd10; d[71:60] = 12'd4095; send_beat(d, 0);
    for (int i = 0; i < 8; i++) send_beat(rnd_beat(), 0);
    drain();
    write_reg(REG_BASE, 14'd10000); write_reg(REG_KP, 14'd4095);
    write_reg(REG_KD, 14'd4095); write_reg(REG_TURN, 14'd8190);
    write_reg(REG_LOST, 14'd4095); write_reg(REG_CEIL, 14'd16383);
    write_reg(REG_FLOOR, 14'd0);
    for (int i = 0; i < 8; i++) send_beat(rnd_beat(), 0);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      for (int r = 0; r < 7; r++)
        if ($urandom_range(1)) write_reg(r[2:0], rnd_reg(r));
      for (int i = 0; i < 200; i++) send_beat(rnd_beat(), (i % 50) < 10);
    end
    drain();
    if (sb.errors == 0 && sb.duty_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
